// ----- rtl/apis_pkg.sv -----
// ----------------------------------------------------------------------------
// apis_pkg
// shared types and defaults for the ring spin lattice microstep block
// ----------------------------------------------------------------------------
package apis_pkg;

  // default sizes
  localparam int DEF_SITES       = 256;
  localparam int DEF_PARTICLES   = 256;
  localparam int DEF_HEIGHT_BITS = 16;

  // field widths fixed by the stream format
  localparam int BETA_W  = 12;
  localparam int LOGIT_W = 16;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = 9;
  localparam int DELTA_W = 3;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 24;

  localparam logic signed [BETA_W-1:0] BETA_RESET = -12'sd128;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_REDUCE,
    ST_LOAD,
    ST_COUNT,
    ST_CNT_LAST,
    ST_RD_S,
    ST_DECIDE,
    ST_WR_R,
    ST_WR_S,
    ST_RD_L,
    ST_RD_P,
    ST_HOP,
    ST_OUT
  } apis_state_e;

endpackage

// ----- rtl/apis_ram.sv -----
// ----------------------------------------------------------------------------
// apis_ram
// generic single-port ram, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module apis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/active_particle_interface_step.sv -----
// ----------------------------------------------------------------------------
// active_particle_interface_step
// one monte carlo microstep of a ring spin lattice with walking particles
// ----------------------------------------------------------------------------
// microstep: the particle scan over the position ram, one stored position per
//   cycle, sets the time from accept to result beat; each modulo subtraction
//   of the index fields adds to it
// load: takes the same modulo subtractions, then writes the position
// one item at a time; the output register lets a result wait for the sink
// reset: an initialising pass writes every site of the spin and height ram, no
//   item is accepted meanwhile; config writes are taken at any time
// ----------------------------------------------------------------------------
module active_particle_interface_step #(
  parameter int SITES       = apis_pkg::DEF_SITES,
  parameter int PARTICLES   = apis_pkg::DEF_PARTICLES,
  parameter int HEIGHT_BITS = apis_pkg::DEF_HEIGHT_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config: beta_gain
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [apis_pkg::BETA_W-1:0]     cfg_data_i,
  // tdata: site_index, logit_draw, particle_index, coin, load_position, pad
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [apis_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func
  input  logic [0:0]                      s_axis_tuser,
  // tdata: bond_flipped, height_delta, neighbour_count, particle_position, pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [apis_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  localparam int SW   = $clog2(SITES);
  localparam int PW   = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int PCW  = $clog2(PARTICLES + 1);
  localparam int HB   = HEIGHT_BITS;
  localparam int HW1  = HB + 1;
  localparam int PRW  = apis_pkg::BETA_W + PCW + 2;
  localparam int CMPW = (PRW > apis_pkg::LOGIT_W) ? PRW + 1 : apis_pkg::LOGIT_W + 1;
  localparam int IW   = apis_pkg::IDX_W;

  localparam logic [SW-1:0]  SITE_LAST = SW'(SITES - 1);
  localparam logic [PCW-1:0] PART_LAST = PCW'(PARTICLES - 1);
  localparam logic [IW-1:0]  RED_S     = (SITES > 255) ? '0 : IW'(SITES);
  localparam logic [IW-1:0]  RED_P     = (PARTICLES > 255) ? '0 : IW'(PARTICLES);
  localparam logic signed [HW1-1:0] H_MAX = HW1'((64'sd1 <<< (HB - 1)) - 64'sd1);
  localparam logic signed [HW1-1:0] H_MIN = -H_MAX - HW1'(1);
  localparam logic signed [HW1-1:0] STEP2 = HW1'(2);

  apis_pkg::apis_state_e state_q, state_d;

  // control
  logic [SW-1:0]                     ic_q;
  logic [PCW-1:0]                    i_q;
  logic                              cmp_q;
  logic                              m_valid_q;
  logic signed [apis_pkg::BETA_W-1:0] beta_q;

  // captured item
  logic                               func_q;
  logic [IW-1:0]                      r_q, pi_q, ld_q;
  logic signed [apis_pkg::LOGIT_W-1:0] logit_q;
  logic                               coin_q;

  // datapath
  logic [PCW-1:0]           cnt_q;
  logic [SW-1:0]            pos_q;
  logic [HB:0]              word_r_q;
  logic signed [PRW-1:0]    prod_q;
  logic                     spin_s_q;
  logic [HB-1:0]            hnew_q;
  logic                     flip_q;
  logic [apis_pkg::DELTA_W-1:0] delta_q;
  logic                     sl_q;
  logic [IW-1:0]            np_q;
  logic [apis_pkg::M_TDATA_W-1:0] m_tdata_q;

  // ram ports
  logic          site_we;
  logic [SW-1:0] site_addr;
  logic [HB:0]   site_wd, site_rd;
  logic          pp_we;
  logic [PW-1:0] pp_addr;
  logic [SW-1:0] pp_wd, pp_rd;

  logic [SW-1:0] r_site, s_site, left_site, right_site, np_site;
  logic [PW-1:0] pi_idx;
  logic          r_big, p_big, l_big;
  logic          in_beat, out_free;

  assign r_site     = SW'(r_q);
  assign s_site     = (r_site == SITE_LAST) ? '0 : r_site + SW'(1);
  assign left_site  = (pos_q == '0) ? SITE_LAST : pos_q - SW'(1);
  assign right_site = (pos_q == SITE_LAST) ? '0 : pos_q + SW'(1);
  assign pi_idx     = PW'(pi_q);

  assign r_big = int'(r_q) >= SITES;
  assign l_big = int'(ld_q) >= SITES;
  assign p_big = int'(pi_q) >= PARTICLES;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // flip decision, shared product of 2*beta*count against the logistic draw
  logic signed [PRW-1:0]  prod_d;
  logic signed [PCW:0]    cnt_ext;
  logic signed [CMPW-1:0] a_ext, lg_ext;
  logic                   spin_r, spin_s, flip_d;
  logic signed [HW1-1:0]  h_old, h_sum, h_sat;

  assign cnt_ext = signed'({1'b0, cnt_q});
  assign prod_d  = PRW'(beta_q) * PRW'(cnt_ext);
  assign a_ext   = CMPW'(prod_q);
  assign lg_ext  = CMPW'(logit_q);
  assign spin_r  = word_r_q[HB];
  assign spin_s  = site_rd[HB];

  always_comb begin
    flip_d = 1'b0;
    if (cnt_q != '0) begin
      if (spin_r && !spin_s) begin
        flip_d = (-a_ext <= lg_ext);
      end else if (!spin_r && spin_s) begin
        flip_d = (a_ext < lg_ext);
      end
    end
  end

  assign h_old = HW1'(signed'(site_rd[HB-1:0]));
  assign h_sum = spin_r ? h_old - STEP2 : h_old + STEP2;
  assign h_sat = (h_sum > H_MAX) ? H_MAX : ((h_sum < H_MIN) ? H_MIN : h_sum);

  // particle hop from the spins left of and at its site
  logic sr;
  assign sr = site_rd[HB];

  always_comb begin
    np_site = pos_q;
    if (sl_q && !sr) begin
      np_site = coin_q ? right_site : left_site;
    end else if (!sl_q && !sr) begin
      np_site = right_site;
    end else if (sl_q && sr) begin
      np_site = left_site;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apis_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    site_we   = 1'b0;
    site_addr = r_site;
    site_wd   = '0;
    pp_we     = 1'b0;
    pp_addr   = i_q[PW-1:0];
    pp_wd     = '0;
    case (state_q)
      apis_pkg::ST_INIT: begin
        // even sites spin up at height 0, odd sites spin down at height 1
        site_we   = 1'b1;
        site_addr = ic_q;
        site_wd   = {~ic_q[0], HB'(ic_q[0])};
        if (ic_q == SITE_LAST) begin
          state_d = apis_pkg::ST_IDLE;
        end
      end
      apis_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = apis_pkg::ST_REDUCE;
        end
      end
      apis_pkg::ST_REDUCE: begin
        if (!r_big && !l_big && !p_big) begin
          state_d = func_q ? apis_pkg::ST_LOAD : apis_pkg::ST_COUNT;
        end
      end
      apis_pkg::ST_LOAD: begin
        pp_we   = 1'b1;
        pp_addr = pi_idx;
        pp_wd   = SW'(ld_q);
        state_d = apis_pkg::ST_OUT;
      end
      apis_pkg::ST_COUNT: begin
        if (i_q == PART_LAST) begin
          state_d = apis_pkg::ST_CNT_LAST;
        end
      end
      apis_pkg::ST_CNT_LAST: begin
        pp_addr = pi_idx;
        state_d = apis_pkg::ST_RD_S;
      end
      apis_pkg::ST_RD_S: begin
        site_addr = s_site;
        state_d   = apis_pkg::ST_DECIDE;
      end
      apis_pkg::ST_DECIDE: begin
        state_d = apis_pkg::ST_WR_R;
      end
      apis_pkg::ST_WR_R: begin
        site_we = flip_q;
        site_wd = {~word_r_q[HB], word_r_q[HB-1:0]};
        state_d = apis_pkg::ST_WR_S;
      end
      apis_pkg::ST_WR_S: begin
        site_we   = flip_q;
        site_addr = s_site;
        site_wd   = {~spin_s_q, hnew_q};
        state_d   = apis_pkg::ST_RD_L;
      end
      apis_pkg::ST_RD_L: begin
        site_addr = left_site;
        state_d   = apis_pkg::ST_RD_P;
      end
      apis_pkg::ST_RD_P: begin
        site_addr = pos_q;
        state_d   = apis_pkg::ST_HOP;
      end
      apis_pkg::ST_HOP: begin
        pp_we   = 1'b1;
        pp_addr = pi_idx;
        pp_wd   = np_site;
        state_d = apis_pkg::ST_OUT;
      end
      apis_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = apis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = apis_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q      <= '0;
      i_q       <= '0;
      cmp_q     <= 1'b0;
      m_valid_q <= 1'b0;
      beta_q    <= apis_pkg::BETA_RESET;
    end else begin
      if (cfg_valid_i) begin
        beta_q <= signed'(cfg_data_i);
      end
      if (state_q == apis_pkg::ST_INIT) begin
        ic_q <= ic_q + SW'(1);
      end
      cmp_q <= (state_q == apis_pkg::ST_COUNT);
      if (in_beat) begin
        i_q <= '0;
      end else if (state_q == apis_pkg::ST_COUNT) begin
        i_q <= i_q + PCW'(1);
      end
      if (state_q == apis_pkg::ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      func_q  <= s_axis_tuser[0];
      r_q     <= s_axis_tdata[7:0];
      logit_q <= signed'(s_axis_tdata[23:8]);
      pi_q    <= s_axis_tdata[31:24];
      coin_q  <= s_axis_tdata[32];
      ld_q    <= s_axis_tdata[40:33];
      cnt_q   <= '0;
      flip_q  <= 1'b0;
      delta_q <= '0;
    end
    if (state_q == apis_pkg::ST_REDUCE) begin
      // index fields wrap by repeated subtraction
      if (r_big) r_q <= r_q - RED_S;
      if (l_big) ld_q <= ld_q - RED_S;
      if (p_big) pi_q <= pi_q - RED_P;
    end
    if (cmp_q && pp_rd == s_site) begin
      cnt_q <= cnt_q + PCW'(1);
    end
    case (state_q)
      apis_pkg::ST_LOAD: begin
        np_q <= ld_q;
      end
      apis_pkg::ST_RD_S: begin
        pos_q    <= pp_rd;
        word_r_q <= site_rd;
        prod_q   <= {prod_d[PRW-2:0], 1'b0};
      end
      apis_pkg::ST_DECIDE: begin
        spin_s_q <= spin_s;
        flip_q   <= flip_d;
        hnew_q   <= HB'(h_sat);
        delta_q  <= flip_d ? apis_pkg::DELTA_W'(h_sat - h_old) : '0;
      end
      apis_pkg::ST_RD_P: begin
        sl_q <= site_rd[HB];
      end
      apis_pkg::ST_HOP: begin
        np_q <= IW'(np_site);
      end
      apis_pkg::ST_OUT: begin
        if (out_free) begin
          m_tdata_q <= {3'b000,
                        np_q,
                        (int'(cnt_q) > 511) ? 9'd511 : apis_pkg::CNT_W'(cnt_q),
                        delta_q,
                        flip_q};
        end
      end
      default: begin
      end
    endcase
  end

  apis_ram #(
    .WIDTH (HB + 1),
    .DEPTH (SITES),
    .AW    (SW)
  ) u_site_ram (
    .clk_i   (clk_i),
    .we_i    (site_we),
    .addr_i  (site_addr),
    .wdata_i (site_wd),
    .rdata_o (site_rd)
  );

  apis_ram #(
    .WIDTH (SW),
    .DEPTH (PARTICLES),
    .AW    (PW)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pp_we),
    .addr_i  (pp_addr),
    .wdata_i (pp_wd),
    .rdata_o (pp_rd)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == apis_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule
